### rtl/core/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg
// Shared types, constants and key-order mapping functions of the radix sorter.
// ----------------------------------------------------------------------------
package lsd_pkg;

    typedef enum logic [1:0] {
        FMT_UINT = 2'd0,
        FMT_SINT = 2'd1,
        FMT_F32  = 2'd2,
        FMT_F64  = 2'd3
    } key_fmt_t;

    localparam int KEY_W = 64;

    // register indexes of the configuration port
    localparam logic [1:0] CFG_KEY_FORMAT    = 2'd0;
    localparam logic [1:0] CFG_INT_WIDTH     = 2'd1;

    // width codes: 0=8, 1=16, 2=32, 3=64 bits
    localparam logic [1:0] WCODE_32 = 2'd2;
    localparam logic [1:0] WCODE_64 = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             last;
    } item_t;

    typedef struct packed {
        key_fmt_t   fmt;
        logic [1:0] wcode;
    } key_cfg_t;

    function automatic logic [1:0] eff_code(input key_fmt_t fmt, input logic [1:0] wcode);
        logic [1:0] c;
        unique case (fmt)
            FMT_F32: c = WCODE_32;
            FMT_F64: c = WCODE_64;
            default: c = wcode;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] key_width(input logic [1:0] code);
        return 7'd8 << code;
    endfunction

    function automatic logic [KEY_W-1:0] code_mask(input logic [1:0] code);
        logic [KEY_W-1:0] m;
        unique case (code)
            2'd0:    m = 64'h0000_0000_0000_00FF;
            2'd1:    m = 64'h0000_0000_0000_FFFF;
            2'd2:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic [KEY_W-1:0] top_bit(input logic [1:0] code);
        logic [KEY_W-1:0] t;
        unique case (code)
            2'd0:    t = 64'h0000_0000_0000_0080;
            2'd1:    t = 64'h0000_0000_0000_8000;
            2'd2:    t = 64'h0000_0000_8000_0000;
            default: t = 64'h8000_0000_0000_0000;
        endcase
        return t;
    endfunction

    // raw pattern -> unsigned order code
    function automatic logic [KEY_W-1:0] map_fwd(input logic [KEY_W-1:0] k,
                                                 input key_fmt_t fmt,
                                                 input logic [1:0] code);
        logic [KEY_W-1:0] m;
        logic [KEY_W-1:0] t;
        logic [KEY_W-1:0] km;
        logic [KEY_W-1:0] r;
        m  = code_mask(code);
        t  = top_bit(code);
        km = k & m;
        unique case (fmt)
            FMT_UINT: r = km;
            FMT_SINT: r = km ^ t;
            default:  r = ((km & t) != '0) ? (~km & m) : (km ^ t);
        endcase
        return r;
    endfunction

    // order code -> raw pattern
    function automatic logic [KEY_W-1:0] map_inv(input logic [KEY_W-1:0] k,
                                                 input key_fmt_t fmt,
                                                 input logic [1:0] code);
        logic [KEY_W-1:0] m;
        logic [KEY_W-1:0] t;
        logic [KEY_W-1:0] km;
        logic [KEY_W-1:0] r;
        m  = code_mask(code);
        t  = top_bit(code);
        km = k & m;
        unique case (fmt)
            FMT_UINT: r = km;
            FMT_SINT: r = km ^ t;
            default:  r = ((km & t) != '0) ? (km ^ t) : (~km & m);
        endcase
        return r;
    endfunction

endpackage

### rtl/core/lsd_ram.sv
// ----------------------------------------------------------------------------
// lsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/lsd_front.sv
// ----------------------------------------------------------------------------
// lsd_front
// Input side: takes key transfers into a two-entry queue for the sort core.
// ----------------------------------------------------------------------------
module lsd_front
    import lsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_item
);

    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    logic        pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid & in_ready;
    assign pop      = q_valid & q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

### rtl/core/lsd_core.sv
// ----------------------------------------------------------------------------
// lsd_core
// Sort core: loads keys, runs the radix passes over two key buffers and a
// bin RAM, then streams the sorted keys out through an output register.
// ----------------------------------------------------------------------------
module lsd_core
    import lsd_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int DIGIT_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  key_cfg_t          cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  item_t             q_item,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [KEY_W-1:0]  out_key,
    output logic              out_final,
    output logic              out_dropped
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int NB = 1 << DIGIT_BITS;
    localparam int SW = 7;

    typedef enum logic [3:0] {
        S_LOAD, S_CLR, S_HRD, S_HBIN, S_HWR, S_PRD, S_PWR,
        S_SRD, S_SBIN, S_SWR, S_ERD, S_EOUT, S_EWAIT
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          count_reg;
    logic                   ovf_reg;
    logic [CW-1:0]          iidx_reg;
    logic [DIGIT_BITS-1:0]  bidx_reg;
    logic [CW-1:0]          sum_reg;
    logic [SW-1:0]          shift_reg;
    logic                   pass0_reg;
    logic                   src_sel_reg;
    key_fmt_t               fmt_reg;
    logic [1:0]             code_reg;
    logic [KEY_W-1:0]       key_reg;
    logic [DIGIT_BITS-1:0]  digit_reg;
    logic                   out_valid_reg;
    logic [KEY_W-1:0]       out_key_reg;
    logic                   out_final_reg;

    logic                   a_we, b_we, bin_we;
    logic [AW-1:0]          a_waddr, b_waddr, key_raddr;
    logic [KEY_W-1:0]       a_wdata, b_wdata, a_rdata, b_rdata;
    logic [DIGIT_BITS-1:0]  bin_waddr, bin_raddr;
    logic [CW-1:0]          bin_wdata, bin_rdata;

    logic [KEY_W-1:0]       src_rdata;
    logic [KEY_W-1:0]       src_key;
    logic [KEY_W-1:0]       src_shifted;
    logic [DIGIT_BITS-1:0]  src_digit;
    logic [CW-1:0]          bin_dec;
    logic [CW-1:0]          prefix_next;
    logic [SW-1:0]          shift_next;
    logic                   load_acc;

    assign q_ready     = (state_reg == S_LOAD);
    assign load_acc    = q_valid & q_ready;
    assign out_valid   = out_valid_reg;
    assign out_key     = out_key_reg;
    assign out_final   = out_final_reg;
    assign out_dropped = ovf_reg;

    assign src_rdata   = src_sel_reg ? b_rdata : a_rdata;
    // first pass reads raw patterns and maps them to order codes
    assign src_key     = pass0_reg ? map_fwd(src_rdata, fmt_reg, code_reg) : src_rdata;
    assign src_shifted = src_key >> shift_reg;
    assign src_digit   = src_shifted[DIGIT_BITS-1:0];
    assign bin_dec     = bin_rdata - CW'(1);
    assign prefix_next = sum_reg + bin_rdata;
    assign shift_next  = shift_reg + SW'(DIGIT_BITS);

    always_comb
    begin
        a_we      = 1'b0;
        b_we      = 1'b0;
        a_waddr   = bin_dec[AW-1:0];
        b_waddr   = bin_dec[AW-1:0];
        a_wdata   = key_reg;
        b_wdata   = key_reg;
        key_raddr = iidx_reg[AW-1:0];
        bin_we    = 1'b0;
        bin_waddr = digit_reg;
        bin_wdata = bin_rdata + CW'(1);
        bin_raddr = src_digit;
        unique case (state_reg)
            S_LOAD:
            begin
                a_waddr = count_reg[AW-1:0];
                a_wdata = q_item.key;
                a_we    = load_acc && (count_reg < CW'(MAX_ITEMS));
            end
            S_CLR:
            begin
                bin_we    = 1'b1;
                bin_waddr = bidx_reg;
                bin_wdata = '0;
            end
            S_HWR:
            begin
                bin_we = 1'b1;
            end
            S_PRD:
            begin
                bin_raddr = bidx_reg;
            end
            S_PWR:
            begin
                bin_we    = 1'b1;
                bin_waddr = bidx_reg;
                bin_wdata = prefix_next;
            end
            S_SWR:
            begin
                bin_we    = 1'b1;
                bin_wdata = bin_dec;
                a_we      = src_sel_reg;
                b_we      = ~src_sel_reg;
            end
            default:
            begin
            end
        endcase
    end

    lsd_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_buf_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (key_raddr),
        .rdata (a_rdata)
    );

    lsd_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_buf_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (key_raddr),
        .rdata (b_rdata)
    );

    lsd_ram #(.WIDTH(CW), .DEPTH(NB)) u_bins (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            iidx_reg      <= '0;
            bidx_reg      <= '0;
            sum_reg       <= '0;
            shift_reg     <= '0;
            pass0_reg     <= 1'b0;
            src_sel_reg   <= 1'b0;
            fmt_reg       <= FMT_UINT;
            code_reg      <= WCODE_64;
            key_reg       <= '0;
            digit_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_key_reg   <= '0;
            out_final_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (load_acc)
                    begin
                        if (count_reg < CW'(MAX_ITEMS))
                        begin
                            count_reg <= count_reg + CW'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (q_item.last)
                        begin
                            fmt_reg     <= cfg.fmt;
                            code_reg    <= eff_code(cfg.fmt, cfg.wcode);
                            shift_reg   <= '0;
                            pass0_reg   <= 1'b1;
                            src_sel_reg <= 1'b0;
                            bidx_reg    <= '0;
                            state_reg   <= S_CLR;
                        end
                    end
                end
                S_CLR:
                begin
                    bidx_reg <= bidx_reg + DIGIT_BITS'(1);
                    if (bidx_reg == '1)
                    begin
                        iidx_reg  <= '0;
                        state_reg <= S_HRD;
                    end
                end
                S_HRD:
                begin
                    state_reg <= S_HBIN;
                end
                S_HBIN:
                begin
                    key_reg   <= src_key;
                    digit_reg <= src_digit;
                    state_reg <= S_HWR;
                end
                S_HWR:
                begin
                    if (iidx_reg + CW'(1) == count_reg)
                    begin
                        bidx_reg  <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_PRD;
                    end
                    else
                    begin
                        iidx_reg  <= iidx_reg + CW'(1);
                        state_reg <= S_HRD;
                    end
                end
                S_PRD:
                begin
                    state_reg <= S_PWR;
                end
                S_PWR:
                begin
                    sum_reg  <= prefix_next;
                    bidx_reg <= bidx_reg + DIGIT_BITS'(1);
                    if (bidx_reg == '1)
                    begin
                        iidx_reg  <= count_reg - CW'(1);
                        state_reg <= S_SRD;
                    end
                    else
                    begin
                        state_reg <= S_PRD;
                    end
                end
                S_SRD:
                begin
                    state_reg <= S_SBIN;
                end
                S_SBIN:
                begin
                    key_reg   <= src_key;
                    digit_reg <= src_digit;
                    state_reg <= S_SWR;
                end
                S_SWR:
                begin
                    if (iidx_reg == '0)
                    begin
                        // pass done: the scatter target becomes the source
                        src_sel_reg <= ~src_sel_reg;
                        pass0_reg   <= 1'b0;
                        shift_reg   <= shift_next;
                        bidx_reg    <= '0;
                        if (shift_next < key_width(code_reg))
                        begin
                            state_reg <= S_CLR;
                        end
                        else
                        begin
                            state_reg <= S_ERD;
                        end
                    end
                    else
                    begin
                        iidx_reg  <= iidx_reg - CW'(1);
                        state_reg <= S_SRD;
                    end
                end
                S_ERD:
                begin
                    state_reg <= S_EOUT;
                end
                S_EOUT:
                begin
                    out_key_reg   <= map_inv(src_rdata, fmt_reg, code_reg);
                    out_final_reg <= (iidx_reg + CW'(1) == count_reg);
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_EWAIT;
                end
                S_EWAIT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_final_reg)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            iidx_reg  <= iidx_reg + CW'(1);
                            state_reg <= S_ERD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("item count beyond capacity");

    a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_EWAIT))
        else $error("result shown outside emit wait");

    a_sort_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LOAD) |-> (count_reg != '0))
        else $error("sort started on empty set");

    a_drop_then_full: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovf_reg) |-> (count_reg == CW'(MAX_ITEMS)))
        else $error("drop flagged before store full");

endmodule

### rtl/core/lsd_radix_sort_engine.sv
// ----------------------------------------------------------------------------
// lsd_radix_sort_engine
// Stable ascending LSD radix sort of key sets with order-preserving mapping.
// ----------------------------------------------------------------------------
// Keys enter a two-entry queue one transfer per cycle while it has room and
// are stored one per cycle while the core loads; up to MAX_ITEMS keys are
// held, further keys are discarded and every result of that set carries
// tuser = 1. The transfer with tlast starts the sort, with the format sampled
// at that moment. Each pass over DIGIT_BITS bits of the order code clears
// the bin RAM, builds a digit histogram, turns it into a prefix sum and
// scatters the keys, last first, into the other key buffer; the number of
// passes is key width / DIGIT_BITS, rounded up. Results then leave one at
// a time, each registered and held until taken, the last one with tlast.
// No input is taken from the queue until the whole set is delivered.
module lsd_radix_sort_engine
    import lsd_pkg::*;
#(
    parameter int MAX_ITEMS  = 64,
    parameter int DIGIT_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [1:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // key_bits[63:0]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // sorted_key[63:0]
    output logic        m_axis_tlast,
    output logic [0:0]  m_axis_tuser    // dropped[0]
);

    key_cfg_t cfg_reg;
    item_t    in_item;
    item_t    q_item;
    logic     q_valid;
    logic     q_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fmt   <= FMT_UINT;
            cfg_reg.wcode <= WCODE_64;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == CFG_KEY_FORMAT)
            begin
                cfg_reg.fmt <= key_fmt_t'(cfg_wdata);
            end
            else if (cfg_index == CFG_INT_WIDTH)
            begin
                cfg_reg.wcode <= cfg_wdata;
            end
        end
    end

    assign in_item.key  = s_axis_tdata;
    assign in_item.last = s_axis_tlast;

    lsd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    lsd_core #(
        .MAX_ITEMS  (MAX_ITEMS),
        .DIGIT_BITS (DIGIT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_key     (m_axis_tdata),
        .out_final   (m_axis_tlast),
        .out_dropped (m_axis_tuser[0])
    );

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream-level check of the LSD radix sorter: key sets in all formats and
// widths, overflowing sets and random idling, compared to an in-bench model.
// ----------------------------------------------------------------------------
module tb;
    import lsd_pkg::*;

    localparam int  CAPACITY   = 64;
    localparam int  N_ITEMS    = 370;
    localparam int  CYC_LIMIT  = 4000000;
    localparam int  SETTLE_CYC = 40;

    typedef struct {
        logic [63:0] key;
        logic        fin;
        logic        drop;
    } sorted_t;

    typedef struct {
        key_fmt_t    fmt;
        logic [1:0]  wcode;
        logic [63:0] key;
        logic        last;
        logic        typed;
        logic [63:0] want;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [1:0]  cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // key_bits[63:0]
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // sorted_key[63:0]
    logic        m_axis_tlast;
    logic [0:0]  m_axis_tuser;   // dropped[0]

    lsd_radix_sort_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // model state
    key_fmt_t    sort_fmt;
    logic [1:0]  sort_wcode;
    logic [63:0] held_keys[$];
    logic        lost_keys;
    sorted_t     sorted_q[$];

    int errors;
    int cycles;
    int sent;
    int idle_pct;
    int stall_pct;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);

    function automatic logic [63:0] width_mask(logic [1:0] code);
        return (code == 2'd3) ? '1 : ((64'd1 << (8 << code)) - 64'd1);
    endfunction

    // order code used for ranking; only the ordering matters here
    function automatic logic [63:0] order_code(logic [63:0] k, key_fmt_t fmt,
                                               logic [1:0] code);
        logic [63:0] m;
        logic [63:0] sgn;
        m   = width_mask(code);
        sgn = 64'd1 << ((8 << code) - 1);
        k   = k & m;
        if (fmt == FMT_UINT)
            return k;
        if (fmt == FMT_SINT)
            return k ^ sgn;
        return ((k & sgn) != 0) ? (~k & m) : (k ^ sgn);
    endfunction

    // accept one key; a last mark sorts the held set into sorted_q
    task automatic load_key(logic [63:0] key, logic last);
        logic [1:0]  code;
        logic [63:0] vals[$];
        logic [63:0] ords[$];
        logic [63:0] tv;
        logic [63:0] to;
        int          j;
        if (held_keys.size() < CAPACITY)
            held_keys.push_back(key);
        else
            lost_keys = 1'b1;
        if (!last)
            return;
        code = (sort_fmt == FMT_F32) ? WCODE_32 :
               (sort_fmt == FMT_F64) ? WCODE_64 : sort_wcode;
        foreach (held_keys[i])
        begin
            vals.push_back(held_keys[i] & width_mask(code));
            ords.push_back(order_code(held_keys[i], sort_fmt, code));
        end
        // stable insertion sort on the order code
        for (int i = 1; i < vals.size(); i++)
        begin
            tv = vals[i];
            to = ords[i];
            j  = i - 1;
            while (j >= 0 && ords[j] > to)
            begin
                vals[j+1] = vals[j];
                ords[j+1] = ords[j];
                j--;
            end
            vals[j+1] = tv;
            ords[j+1] = to;
        end
        foreach (vals[i])
            sorted_q.push_back('{vals[i], (i == vals.size() - 1), lost_keys});
        held_keys.delete();
        lost_keys = 1'b0;
    endtask

    // result checker; values at the falling edge are those of the next transfer
    always @(negedge clk)
    begin
        sorted_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sorted_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result key=%h", m_axis_tdata);
            end
            else
            begin
                e = sorted_q.pop_front();
                if (e.key !== m_axis_tdata || e.fin !== m_axis_tlast
                    || e.drop !== m_axis_tuser[0])
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp key=%h last=%b drop=%b got key=%h last=%b drop=%b",
                                 e.key, e.fin, e.drop, m_axis_tdata, m_axis_tlast,
                                 m_axis_tuser[0]);
                end
            end
        end
    end

    // sender stays idle until every expected result has come
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_KEY_FORMAT)
            sort_fmt = key_fmt_t'(val);
        else if (idx == CFG_INT_WIDTH)
            sort_wcode = val;
        @(posedge clk);
    endtask

    task automatic set_format(key_fmt_t fmt, logic [1:0] wcode);
        if (fmt == sort_fmt && wcode == sort_wcode)
            return;
        wait_drained();
        reg_write(CFG_KEY_FORMAT, fmt);
        reg_write(CFG_INT_WIDTH, wcode);
    endtask

    task automatic send_key(logic [63:0] key, logic last);
        logic took;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        s_axis_tlast  <= last;
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
            @(posedge clk);
        end while (!took);
        load_key(key, last);
        sent++;
        if (sent == 120)
        begin
            idle_pct  = 70;
            stall_pct = 20;
        end
        else if (sent == 250)
        begin
            idle_pct  = 0;
            stall_pct = 0;
        end
    endtask

    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        case ($urandom_range(0, 6))
            0:       k = '0;
            1:       k = '1;
            2:       k = 64'd1 << $urandom_range(0, 63);
            3:       k = {$urandom, $urandom} | (64'd1 << (8 << $urandom_range(0, 3)) - 1);
            4:       k = $urandom_range(0, 3);
            default: k = {$urandom, $urandom};
        endcase
        return k;
    endfunction

    row_t rows[$];

    initial
    begin
        int n;
        errors        = 0;
        cycles        = 0;
        sent          = 0;
        idle_pct      = 20;
        stall_pct     = 70;
        sort_fmt      = FMT_UINT;
        sort_wcode    = WCODE_64;
        lost_keys     = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;

        // single-key sets carry a typed result; multi-key sets use the model
        rows = '{
            '{FMT_UINT, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF},
            '{FMT_UINT, 2'd3, 64'h0,                   1'b1, 1'b1, 64'h0},
            '{FMT_UINT, 2'd0, 64'hFFFF_FFFF_FFFF_FF80, 1'b1, 1'b1, 64'h80},
            '{FMT_UINT, 2'd1, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b1, 64'hDEF0},
            '{FMT_UINT, 2'd2, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b1, 64'h9ABC_DEF0},
            '{FMT_UINT, 2'd2, 64'hFFFF_FFFF_0000_0001, 1'b0, 1'b0, 64'h0},
            '{FMT_UINT, 2'd2, 64'h0000_0000_0000_0001, 1'b0, 1'b0, 64'h0},
            '{FMT_UINT, 2'd2, 64'h0000_0000_8000_0000, 1'b1, 1'b0, 64'h0},
            '{FMT_SINT, 2'd0, 64'h7F,                  1'b0, 1'b0, 64'h0},
            '{FMT_SINT, 2'd0, 64'h80,                  1'b0, 1'b0, 64'h0},
            '{FMT_SINT, 2'd0, 64'hFF00,                1'b1, 1'b0, 64'h0},
            '{FMT_SINT, 2'd3, 64'h8000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
            '{FMT_SINT, 2'd3, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 64'h0},
            '{FMT_SINT, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, 64'h0},
            '{FMT_F32,  2'd0, 64'h8000_0000,           1'b1, 1'b1, 64'h8000_0000},
            '{FMT_F32,  2'd0, 64'h3F80_0000,           1'b0, 1'b0, 64'h0},
            '{FMT_F32,  2'd0, 64'hBF80_0000,           1'b0, 1'b0, 64'h0},
            '{FMT_F32,  2'd0, 64'hFFFF_FFFF_7FC0_0000, 1'b0, 1'b0, 64'h0},
            '{FMT_F32,  2'd0, 64'h0,                   1'b1, 1'b0, 64'h0},
            '{FMT_F64,  2'd1, 64'hFFF8_0000_0000_0000, 1'b1, 1'b1, 64'hFFF8_0000_0000_0000},
            '{FMT_F64,  2'd1, 64'hC000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
            '{FMT_F64,  2'd1, 64'h4000_0000_0000_0000, 1'b0, 1'b0, 64'h0},
            '{FMT_F64,  2'd1, 64'h8000_0000_0000_0000, 1'b1, 1'b0, 64'h0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (i == 0 || rows[i-1].last)
                set_format(rows[i].fmt, rows[i].wcode);
            send_key(rows[i].key, rows[i].last);
            if (rows[i].typed)
                sorted_q[$].key = rows[i].want;
        end

        // writes to unused register indexes must have no effect
        wait_drained();
        reg_write(2'd2, 2'd1);
        reg_write(2'd3, 2'd2);

        while (sent < N_ITEMS)
        begin
            if ($urandom_range(0, 99) < 30)
                set_format(key_fmt_t'(2'($urandom_range(0, 3))), 2'($urandom_range(0, 3)));
            case ($urandom_range(0, 19))
                0:       n = $urandom_range(65, 70);   // overflowing set
                1, 2:    n = $urandom_range(20, 64);
                default: n = $urandom_range(1, 10);
            endcase
            for (int k = 0; k < n; k++)
                send_key(rand_key(), k == n - 1);
            if ($urandom_range(0, 99) < 5)
                wait_drained();
        end

        wait_drained();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/core/lsd_pkg.sv
rtl/core/lsd_ram.sv
rtl/core/lsd_front.sv
rtl/core/lsd_core.sv
rtl/core/lsd_radix_sort_engine.sv
bench/tb.sv
